### src/tbbd_pkg.sv
// Shared types, constants and a helper function for the trail grid blur/decay block.
package tbbd_pkg;

  // Grid geometry defaults and limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MIN_SIDE       = 16;

  // Field and register widths
  localparam int SIDE_W    = 9;
  localparam int COORD_W   = 8;
  localparam int CELL_W    = 32;
  localparam int KEEP_W    = 17;
  localparam int RAD_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Keep factor of exactly one in Q1.16
  localparam logic [KEEP_W-1:0] KEEP_ONE   = 17'h10000;
  localparam int                KEEP_SHIFT = 16;

  // Datapath widths: product of cell and keep, sum of up to 25 products
  localparam int PROD_W    = CELL_W + KEEP_W;
  localparam int ACC_W     = PROD_W + 5;
  localparam int Q_BITS    = ACC_W - KEEP_SHIFT;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (Q_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W     = DIV_STEPS * DIV_BITS;
  localparam int REM_W     = 5;

  // Window cell counts
  localparam logic [REM_W-1:0] N_3X3 = 5'd9;
  localparam logic [REM_W-1:0] N_5X5 = 5'd25;

  // Register reset values
  localparam logic [SIDE_W-1:0] GRID_WIDTH_RST    = 9'd256;
  localparam logic [SIDE_W-1:0] GRID_HEIGHT_RST   = 9'd256;
  localparam logic              WRAP_MODE_RST     = 1'b1;
  localparam logic [RAD_W-1:0]  KERNEL_RADIUS_RST = 2'd1;
  localparam logic [KEEP_W-1:0] KEEP_FACTOR_RST   = 17'd64225;
  localparam logic [CELL_W-1:0] TRAIL_CEILING_RST = 32'd1280000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FACTOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_CEILING = 3'd5;

  // Item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_FILTER = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

  // Neighbor coordinate c + d inside [0, n), by wraparound or by edge clamp
  function automatic logic [SIDE_W-1:0] nbr_coord(input logic [SIDE_W-1:0] c,
                                                  input logic signed [2:0] d,
                                                  input logic [SIDE_W-1:0] n,
                                                  input logic wrap);
    logic signed [SIDE_W+1:0] s;
    logic signed [SIDE_W+1:0] ns;
    ns = $signed({2'b00, n});
    s  = $signed({2'b00, c}) + $signed({{(SIDE_W-1){d[2]}}, d});
    if (wrap) begin
      if (s[SIDE_W+1]) begin
        s = s + ns;
      end else if (s >= ns) begin
        s = s - ns;
      end
    end else begin
      if (s[SIDE_W+1]) begin
        s = '0;
      end else if (s >= ns) begin
        s = ns - $signed((SIDE_W+2)'(1));
      end
    end
    return s[SIDE_W-1:0];
  endfunction

endpackage

### src/trail_box_blur_decay.sv
// Top level of the trail grid box blur with decay block.
// Holds a MAX_WIDTH x MAX_HEIGHT grid of Q24.8 trail cells in one single-port RAM.
// After reset a clearing pass writes zero to every cell, one per cycle; no beat
// is taken meanwhile, while configuration writes are. A load beat is written to
// the RAM as it is accepted. A filter beat reads its window through the single
// RAM port, one cell a cycle, multiplies each cell by the keep factor and sums,
// then, but at radius 0, divides by the window size four quotient bits a cycle.
// A filter beat with an address outside the grid skips the window and yields zero.
// The input is ready only in the idle state; a result waiting in the output
// register does not block load beats or the start of the next filter beat.
module trail_box_blur_decay #(
  parameter int MAX_WIDTH  = tbbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tbbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [tbbd_pkg::COORD_W-1:0]   in_col,
  input  logic [tbbd_pkg::COORD_W-1:0]   in_row,
  input  logic [tbbd_pkg::CELL_W-1:0]    in_cell_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tbbd_pkg::CELL_W-1:0]    out_filtered_value,
  input  logic                           cfg_we,
  input  logic [tbbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbbd_pkg::CELL_W-1:0]    cfg_wdata
);

  import tbbd_pkg::*;

  localparam int             DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int             AW         = $clog2(DEPTH);
  localparam logic [AW-1:0]  ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [AW-1:0]  LAST_ADDR  = AW'(DEPTH - 1);
  localparam int             DCW        = $clog2(DIV_STEPS);

  // Configuration registers
  logic [SIDE_W-1:0] grid_width_r;
  logic [SIDE_W-1:0] grid_height_r;
  logic              wrap_mode_r;
  logic [RAD_W-1:0]  kernel_radius_r;
  logic [KEEP_W-1:0] keep_factor_r;
  logic [CELL_W-1:0] trail_ceiling_r;

  // Effective settings
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [RAD_W-1:0]  rad_eff;
  logic [KEEP_W-1:0] keep_eff;
  logic [REM_W-1:0]  win_n;
  logic signed [2:0] r_pos;

  // Sequencer
  state_t        state_r;
  state_t        state_nxt;
  logic          in_acc;
  logic          in_inside;
  logic          win_last;
  logic          drain_done;
  logic          rd_issue;
  logic          clr_we;
  logic          out_load;
  logic [AW-1:0] clr_addr_r;

  // Window walk
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic signed [2:0]  dy_r;
  logic signed [2:0]  dx_r;
  logic [SIDE_W-1:0]  sy;
  logic [SIDE_W-1:0]  sx;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      in_addr;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  // Arithmetic
  logic              rd_vld_r;
  logic              prod_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [Q_BITS-1:0] acc_q;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  quo_nxt;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [DCW-1:0]    div_cnt_r;
  logic [CELL_W-1:0] capped;
  logic [CELL_W-1:0] res_r;
  logic [CELL_W-1:0] out_value_r;
  logic              out_valid_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= GRID_WIDTH_RST;
      grid_height_r   <= GRID_HEIGHT_RST;
      wrap_mode_r     <= WRAP_MODE_RST;
      kernel_radius_r <= KERNEL_RADIUS_RST;
      keep_factor_r   <= KEEP_FACTOR_RST;
      trail_ceiling_r <= TRAIL_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:    grid_width_r    <= cfg_wdata[SIDE_W-1:0];
        CFG_GRID_HEIGHT:   grid_height_r   <= cfg_wdata[SIDE_W-1:0];
        CFG_WRAP_MODE:     wrap_mode_r     <= cfg_wdata[0];
        CFG_KERNEL_RADIUS: kernel_radius_r <= cfg_wdata[RAD_W-1:0];
        CFG_KEEP_FACTOR:   keep_factor_r   <= cfg_wdata[KEEP_W-1:0];
        CFG_TRAIL_CEILING: trail_ceiling_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate settings to their usable ranges
  always_comb begin
    if (grid_width_r < SIDE_W'(MIN_SIDE)) begin
      w_eff = SIDE_W'(MIN_SIDE);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = SIDE_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r < SIDE_W'(MIN_SIDE)) begin
      h_eff = SIDE_W'(MIN_SIDE);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = SIDE_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
    rad_eff  = (kernel_radius_r == 2'd3) ? 2'd2 : kernel_radius_r;
    keep_eff = (keep_factor_r > KEEP_ONE) ? KEEP_ONE : keep_factor_r;
    win_n    = (rad_eff == 2'd1) ? N_3X3 : N_5X5;
    r_pos    = $signed({1'b0, rad_eff});
  end

  assign in_acc     = in_valid && in_ready;
  assign in_inside  = ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);
  assign win_last   = (dx_r == r_pos) && (dy_r == r_pos);
  assign drain_done = !rd_vld_r && !prod_vld_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_FILTER) begin
          state_nxt = in_inside ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        if (win_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = (rad_eff == 2'd0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    clr_we   = (state_r == ST_CLEAR);
    rd_issue = (state_r == ST_READ);
    out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  // Window and load addresses
  always_comb begin
    sy      = nbr_coord({1'b0, row_r}, dy_r, h_eff, wrap_mode_r);
    sx      = nbr_coord({1'b0, col_r}, dx_r, w_eff, wrap_mode_r);
    rd_addr = AW'(sy) * ROW_STRIDE + AW'(sx);
    in_addr = AW'(in_row) * ROW_STRIDE + AW'(in_col);
  end

  // Steer the single RAM port
  always_comb begin
    if (clr_we) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
    end else if (rd_issue) begin
      ram_we    = 1'b0;
      ram_addr  = rd_addr;
      ram_wdata = in_cell_value;
    end else begin
      ram_we    = in_acc && (in_kind == KIND_LOAD) && in_inside;
      ram_addr  = in_addr;
      ram_wdata = in_cell_value;
    end
  end

  tbbd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Divide the scaled sum by the window size, several quotient bits per cycle
  always_comb begin
    logic [REM_W:0] trial;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, win_n}) begin
        rem_nxt    = REM_W'(trial - {1'b0, win_n});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[REM_W-1:0];
      end
    end
  end

  assign acc_q  = acc_r[ACC_W-1:KEEP_SHIFT];
  assign capped = (quo_nxt[CELL_W-1:0] > trail_ceiling_r) ? trail_ceiling_r
                                                          : quo_nxt[CELL_W-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= rd_issue;
      prod_vld_r <= rd_vld_r;
      if (clr_we) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Capture a filter beat and start its window walk
    if (in_acc && in_kind == KIND_FILTER) begin
      col_r <= in_col;
      row_r <= in_row;
      dy_r  <= -r_pos;
      dx_r  <= -r_pos;
      acc_r <= '0;
      res_r <= '0;
    end
    // Advance through the window, row by row
    if (rd_issue) begin
      if (dx_r == r_pos) begin
        dx_r <= -r_pos;
        dy_r <= dy_r + 3'sd1;
      end else begin
        dx_r <= dx_r + 3'sd1;
      end
    end
    // Scale each cell by the keep factor and accumulate
    prod_r <= {{KEEP_W{1'b0}}, ram_rdata} * {{CELL_W{1'b0}}, keep_eff};
    if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    // Hand the scaled sum to the divider, or finish at radius 0
    if (state_r == ST_DRAIN && drain_done) begin
      if (rad_eff == 2'd0) begin
        res_r <= acc_q[CELL_W-1:0];
      end else begin
        quo_r     <= QUO_W'(acc_q);
        rem_r     <= '0;
        div_cnt_r <= DCW'(DIV_STEPS - 1);
      end
    end
    // Iterate the divider and cap the quotient on the last step
    if (state_r == ST_DIV) begin
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == '0) begin
        res_r <= capped;
      end
    end
    if (out_load) begin
      out_value_r <= res_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

  // The store is written only while clearing or idle
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("store written while a filter is in progress");

  // The multiply-accumulate pipeline is empty before dividing
  a_div_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (!rd_vld_r && !prod_vld_r))
    else $error("divider started with reads in flight");

  // A result only appears after the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

  // The window walk only leaves toward the drain
  a_read_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_READ || state_r == ST_DRAIN))
    else $error("window walk left early");

endmodule

### src/tbbd_ram.sv
// Generic single-port RAM with registered read data.
module tbbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, register the read port every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### test/trail_box_blur_decay_tb.sv
`timescale 1ns / 100ps
// Testbench for trail_box_blur_decay: own grid predictor, queued stimulus, random idling.
module trail_box_blur_decay_tb;
  import tbbd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;

  // Register indexes that the block does not implement
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CELL_W-1:0]  value;
  } trail_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_LOAD;
  logic [COORD_W-1:0]   in_col = '0;
  logic [COORD_W-1:0]   in_row = '0;
  logic [CELL_W-1:0]    in_cell_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    out_filtered_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_WIDTH;
  logic [CELL_W-1:0]    cfg_wdata = '0;

  // Mirror of the grid and of the registers
  logic [CELL_W-1:0] trail_mirror [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
  logic [SIDE_W-1:0] cur_width   = GRID_WIDTH_RST;
  logic [SIDE_W-1:0] cur_height  = GRID_HEIGHT_RST;
  logic              cur_wrap    = WRAP_MODE_RST;
  logic [RAD_W-1:0]  cur_radius  = KERNEL_RADIUS_RST;
  logic [KEEP_W-1:0] cur_keep    = KEEP_FACTOR_RST;
  logic [CELL_W-1:0] cur_ceiling = TRAIL_CEILING_RST;

  trail_beat_t       beat_q [$];
  logic [CELL_W-1:0] filtered_due [$];
  trail_beat_t       next_beat;
  int                send_gap = 0;
  int                recv_gap = 0;
  bit                no_idle = 1'b0;
  int                fault_count = 0;
  int                cycle_count = 0;

  trail_box_blur_decay DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_cell_value      (in_cell_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Saturate a side register to the usable range
  function automatic int unsigned side_eff(input logic [SIDE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIDE) return MIN_SIDE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Neighbor position p folded into [0, n) by wraparound or edge clamp
  function automatic int fold_coord(input int p, input int n, input logic wrap);
    int s;
    s = p;
    if (wrap) begin
      if (s < 0) s = s + n;
      else if (s >= n) s = s - n;
    end else begin
      if (s < 0) s = 0;
      else if (s >= n) s = n - 1;
    end
    return s;
  endfunction

  // Filtered value of cell (r, c) under the current registers
  function automatic logic [CELL_W-1:0] blur_expect(input logic [COORD_W-1:0] c,
                                                    input logic [COORD_W-1:0] r);
    int          w, h, rad, dy, dx, sy, sx;
    logic [63:0] keep, acc, span, q;
    w    = side_eff(cur_width, MAX_WIDTH_DEF);
    h    = side_eff(cur_height, MAX_HEIGHT_DEF);
    rad  = (cur_radius > 2) ? 2 : cur_radius;
    keep = (cur_keep > KEEP_ONE) ? 64'(KEEP_ONE) : 64'(cur_keep);
    if (c >= w || r >= h) return '0;
    // Decay only: no window, no cap
    if (rad == 0) begin
      q = (64'(trail_mirror[{r, c}]) * keep) >> KEEP_SHIFT;
      return q[CELL_W-1:0];
    end
    acc = '0;
    for (dy = -rad; dy <= rad; dy++) begin
      sy = fold_coord(int'(r) + dy, h, cur_wrap);
      for (dx = -rad; dx <= rad; dx++) begin
        sx = fold_coord(int'(c) + dx, w, cur_wrap);
        acc = acc + 64'(trail_mirror[16'(sy * MAX_WIDTH_DEF + sx)]);
      end
    end
    span = 64'((2 * rad + 1) * (2 * rad + 1));
    q = (acc * keep) / (span << KEEP_SHIFT);
    if (q > 64'(cur_ceiling)) q = 64'(cur_ceiling);
    return q[CELL_W-1:0];
  endfunction

  // Cell values biased toward the extremes
  function automatic logic [CELL_W-1:0] rand_cell();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return '0;
      2: return $urandom_range(0, 255);
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Coordinate in [0, n), often on or next to an edge
  function automatic int unsigned pick_coord(input int unsigned n);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return n - 2;
      3: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic queue_beat(input logic k, input logic [COORD_W-1:0] c,
                            input logic [COORD_W-1:0] r, input logic [CELL_W-1:0] v);
    trail_beat_t b;
    b.kind  = k;
    b.col   = c;
    b.row   = r;
    b.value = v;
    beat_q.push_back(b);
  endtask

  // Write one register and track it in the mirror
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CELL_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GRID_WIDTH:    cur_width   = data[SIDE_W-1:0];
      CFG_GRID_HEIGHT:   cur_height  = data[SIDE_W-1:0];
      CFG_WRAP_MODE:     cur_wrap    = data[0];
      CFG_KERNEL_RADIUS: cur_radius  = data[RAD_W-1:0];
      CFG_KEEP_FACTOR:   cur_keep    = data[KEEP_W-1:0];
      CFG_TRAIL_CEILING: cur_ceiling = data;
      default: ;
    endcase
  endtask

  // Write all registers, with junk above each register's width
  task automatic set_config(input int w, input int h, input int wrap, input int rad,
                            input int keep, input logic [CELL_W-1:0] ceiling,
                            input bit poke_spare);
    cfg_write(CFG_GRID_WIDTH, ($urandom << SIDE_W) | 32'(w));
    cfg_write(CFG_GRID_HEIGHT, ($urandom << SIDE_W) | 32'(h));
    cfg_write(CFG_WRAP_MODE, ($urandom << 1) | 32'(wrap));
    cfg_write(CFG_KERNEL_RADIUS, ($urandom << RAD_W) | 32'(rad));
    cfg_write(CFG_KEEP_FACTOR, ($urandom << KEEP_W) | 32'(keep));
    cfg_write(CFG_TRAIL_CEILING, ceiling);
    if (poke_spare) begin
      cfg_write(CFG_SPARE_A, $urandom);
      cfg_write(CFG_SPARE_B, $urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every beat is taken and every result is back, then let the block settle
  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid || filtered_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly load a neighborhood and filter around it; the rest is noise anywhere
  task automatic run_mix(input int target);
    int                 made;
    int unsigned        w, h, cc, cr, n;
    logic [COORD_W-1:0] c, r;
    logic               k;
    made = 0;
    w = side_eff(cur_width, MAX_WIDTH_DEF);
    h = side_eff(cur_height, MAX_HEIGHT_DEF);
    while (made < target) begin
      if ($urandom_range(0, 4) == 0) begin
        k = 1'($urandom_range(0, 1));
        c = COORD_W'($urandom_range(0, 255));
        r = COORD_W'($urandom_range(0, 255));
        queue_beat(k, c, r, rand_cell());
        if (k == KIND_FILTER || (c < w && r < h)) made++;
      end else begin
        cc = pick_coord(w);
        cr = pick_coord(h);
        n  = $urandom_range(2, 10);
        repeat (n) begin
          queue_beat(KIND_LOAD, COORD_W'((cc + w + $urandom_range(0, 4) - 2) % w),
                     COORD_W'((cr + h + $urandom_range(0, 4) - 2) % h), rand_cell());
        end
        made = made + n;
        n = $urandom_range(1, 3);
        repeat (n) begin
          queue_beat(KIND_FILTER, COORD_W'((cc + w + $urandom_range(0, 2) - 1) % w),
                     COORD_W'((cr + h + $urandom_range(0, 2) - 1) % h), rand_cell());
        end
        made = made + n;
      end
    end
  endtask

  // Drive input beats; predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_kind == KIND_FILTER) begin
          filtered_due.push_back(blur_expect(in_col, in_row));
        end else if (in_col < side_eff(cur_width, MAX_WIDTH_DEF) &&
                     in_row < side_eff(cur_height, MAX_HEIGHT_DEF)) begin
          trail_mirror[{in_row, in_col}] = in_cell_value;
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          if (!no_idle && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 7);
            in_valid <= 1'b0;
          end else begin
            next_beat = beat_q.pop_front();
            in_valid      <= 1'b1;
            in_kind       <= next_beat.kind;
            in_col        <= next_beat.col;
            in_row        <= next_beat.row;
            in_cell_value <= next_beat.value;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result beats against the oldest prediction; stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   out_filtered_value);
          fault_count++;
        end else if (out_filtered_value !== filtered_due[0]) begin
          $display("%0t: filtered_value mismatch, expected %h, actual %h", $time,
                   filtered_due[0], out_filtered_value);
          fault_count++;
          void'(filtered_due.pop_front());
        end else begin
          void'(filtered_due.pop_front());
        end
      end
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("trail_box_blur_decay test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF * MAX_HEIGHT_DEF; i++) trail_mirror[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: full grid, wraparound over the far corners
    queue_beat(KIND_LOAD, 8'd0, 8'd0, 32'hFFFF_FFFF);
    queue_beat(KIND_LOAD, 8'd255, 8'd255, 32'hFFFF_FFFF);
    queue_beat(KIND_LOAD, 8'd255, 8'd0, 32'h1234_5678);
    queue_beat(KIND_LOAD, 8'd0, 8'd255, 32'h0000_0001);
    queue_beat(KIND_FILTER, 8'd0, 8'd0, '0);
    queue_beat(KIND_FILTER, 8'd255, 8'd255, 32'hFFFF_FFFF);
    queue_beat(KIND_FILTER, 8'd128, 8'd128, '0);
    run_mix(60);
    wait_idle();

    // Smallest grid, edge clamp, 5x5, no decay, no cap; addresses off the grid
    set_config(16, 16, 0, 2, 65536, 32'hFFFF_FFFF, 1'b0);
    @(negedge clk);
    queue_beat(KIND_LOAD, 8'd15, 8'd15, 32'hFFFF_FFFF);
    queue_beat(KIND_LOAD, 8'd16, 8'd3, 32'hAAAA_5555);
    queue_beat(KIND_LOAD, 8'd3, 8'd16, 32'h5555_AAAA);
    queue_beat(KIND_FILTER, 8'd0, 8'd0, '0);
    queue_beat(KIND_FILTER, 8'd15, 8'd15, '0);
    queue_beat(KIND_FILTER, 8'd16, 8'd3, '0);
    queue_beat(KIND_FILTER, 8'd3, 8'd16, '0);
    queue_beat(KIND_FILTER, 8'd255, 8'd255, '0);
    run_mix(60);
    wait_idle();

    // Sides out of range, radius three, keep above one, unused indexes
    set_config(5, 300, 1, 3, 131071, 32'd1000, 1'b1);
    @(negedge clk);
    run_mix(60);
    wait_idle();

    // Decay only with keep zero
    set_config(256, 16, 0, 0, 0, 32'd0, 1'b0);
    @(negedge clk);
    run_mix(40);
    wait_idle();

    // Decay only never takes the cap
    set_config(20, 256, 1, 0, 65535, 32'd0, 1'b0);
    @(negedge clk);
    run_mix(60);
    wait_idle();

    set_config(37, 23, 1, 2, $urandom_range(0, 65536), $urandom, 1'b0);
    @(negedge clk);
    run_mix(60);
    wait_idle();

    set_config(511, 0, 0, 1, 40000, 32'h0010_0000, 1'b1);
    @(negedge clk);
    run_mix(60);
    wait_idle();

    // Back to the reset settings at full rate
    set_config(256, 256, 1, 1, 64225, 32'd1280000, 1'b0);
    @(negedge clk);
    no_idle = 1'b1;
    run_mix(60);
    wait_idle();

    if (fault_count == 0) begin
      $display("trail_box_blur_decay test passed");
    end else begin
      $display("trail_box_blur_decay test failed");
    end
    $finish;
  end

endmodule
